>>> hdl/drp_pkg.sv
// Shared types, codes and helpers for the document record parser.
package drp_pkg;

    // Parse phases
    localparam logic [3:0] PH_ID        = 4'd0;
    localparam logic [3:0] PH_DIMS      = 4'd1;
    localparam logic [3:0] PH_FCOUNT    = 4'd2;
    localparam logic [3:0] PH_EMB       = 4'd3;
    localparam logic [3:0] PH_KEYLEN    = 4'd4;
    localparam logic [3:0] PH_KEYBYTES  = 4'd5;
    localparam logic [3:0] PH_TYPE      = 4'd6;
    localparam logic [3:0] PH_BOOL      = 4'd7;
    localparam logic [3:0] PH_INT       = 4'd8;
    localparam logic [3:0] PH_DBL       = 4'd9;
    localparam logic [3:0] PH_STRLEN    = 4'd10;
    localparam logic [3:0] PH_STRBYTES  = 4'd11;

    // Token kinds
    localparam logic [3:0] KIND_NONE     = 4'd0;
    localparam logic [3:0] KIND_ID       = 4'd1;
    localparam logic [3:0] KIND_DIMS     = 4'd2;
    localparam logic [3:0] KIND_FCOUNT   = 4'd3;
    localparam logic [3:0] KIND_EMB      = 4'd4;
    localparam logic [3:0] KIND_KEYLEN   = 4'd5;
    localparam logic [3:0] KIND_KEYBYTE  = 4'd6;
    localparam logic [3:0] KIND_TYPE     = 4'd7;
    localparam logic [3:0] KIND_BOOL     = 4'd8;
    localparam logic [3:0] KIND_INT      = 4'd9;
    localparam logic [3:0] KIND_DBL      = 4'd10;
    localparam logic [3:0] KIND_STRLEN   = 4'd11;
    localparam logic [3:0] KIND_STRBYTE  = 4'd12;

    // Parse status
    localparam logic [1:0] ST_BUSY      = 2'd0;
    localparam logic [1:0] ST_DONE      = 2'd1;
    localparam logic [1:0] ST_TRUNC     = 2'd2;
    localparam logic [1:0] ST_BADTYPE   = 2'd3;

    // Finished flags
    localparam logic [1:0] FLAG_DONE    = 2'b01;
    localparam logic [1:0] FLAG_ERR     = 2'b10;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W   = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_NIL    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOOL   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STRING = 3'd4;

    typedef struct packed {
        logic [7:0] nil_code;
        logic [7:0] bool_code;
        logic [7:0] int_code;
        logic [7:0] double_code;
        logic [7:0] string_code;
    } type_codes_t;

    typedef struct packed {
        logic        emit;
        logic [3:0]  kind;
        logic [63:0] value;
        logic [15:0] field;
        logic [1:0]  status;
    } token_t;

    // Bytes per token for each phase
    function automatic logic [3:0] word_len(input logic [3:0] ph);
        logic [3:0] len;
        unique case (ph)
            PH_ID, PH_INT, PH_DBL:        len = 4'd8;
            PH_DIMS, PH_EMB:              len = 4'd4;
            PH_FCOUNT, PH_KEYLEN,
            PH_STRLEN:                    len = 4'd2;
            default:                      len = 4'd1;
        endcase
        return len;
    endfunction

endpackage

>>> hdl/drp_if.sv
// Byte and token channel interfaces.
interface drp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_buffer;

    modport source (output valid, output data_byte, output end_of_buffer, input ready);
    modport sink   (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

interface drp_token_if;
    logic        valid;
    logic        ready;
    logic [3:0]  token_kind;
    logic [63:0] token_value;
    logic [15:0] field_number;
    logic [1:0]  parse_status;

    modport source (output valid, output token_kind, output token_value,
                    output field_number, output parse_status, input ready);
    modport sink   (input valid, input token_kind, input token_value,
                    input field_number, input parse_status, output ready);
endinterface

>>> hdl/document_record_parser.sv
// Top level: input byte register, parser step, result register.
// A transferred byte waits in the input byte register; its token enters the result register when the parser steps.
// The parser takes one byte per cycle while the result register is free or drains.
// Input register and result register let a byte transfer while a token waits.
// Reset (rst_n, async, active low): parser to header id phase, empty registers,
// type codes to nil 0, bool 1, int 2, double 3, string 4.
module document_record_parser
(
    input  logic                            clk,
    input  logic                            rst_n,
    drp_byte_if.sink                        bytes,
    drp_token_if.source                     tokens,
    input  logic                            cfg_we,
    input  logic [drp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [7:0]                      cfg_data
);

    drp_pkg::type_codes_t codes;
    drp_pkg::token_t      tok;

    // input byte register
    logic        in_vld_reg,  in_vld_next;
    logic [7:0]  byte_reg;
    logic        eob_reg;

    // result register
    logic            out_vld_reg, out_vld_next;
    drp_pkg::token_t res_reg;

    logic advance;
    logic in_take;

    // The parser steps whenever a byte is held and the result slot is free
    // or drains this cycle. Bytes with no token just retire.
    assign advance = in_vld_reg && (!out_vld_reg || tokens.ready);
    assign bytes.ready = !in_vld_reg || advance;
    assign in_take = bytes.valid && bytes.ready;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (in_take)
            in_vld_next = 1'b1;
        else if (advance)
            in_vld_next = 1'b0;

        out_vld_next = out_vld_reg;
        if (advance)
            out_vld_next = tok.emit;
        else if (tokens.ready)
            out_vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            byte_reg <= bytes.data_byte;
            eob_reg  <= bytes.end_of_buffer;
        end
        if (advance && tok.emit)
        begin
            res_reg <= tok;
        end
    end

    drp_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .codes     (codes)
    );

    drp_core u_core
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (advance),
        .data_byte     (byte_reg),
        .end_of_buffer (eob_reg),
        .codes         (codes),
        .tok           (tok)
    );

    assign tokens.valid        = out_vld_reg;
    assign tokens.token_kind   = res_reg.kind;
    assign tokens.token_value  = res_reg.value;
    assign tokens.field_number = res_reg.field;
    assign tokens.parse_status = res_reg.status;

endmodule

>>> hdl/drp_cfg.sv
// Type code registers.
module drp_cfg
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [drp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [7:0]                      cfg_data,
    output drp_pkg::type_codes_t            codes
);

    drp_pkg::type_codes_t codes_reg;
    drp_pkg::type_codes_t codes_next;

    always_comb
    begin
        codes_next = codes_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                drp_pkg::CFG_NIL:    codes_next.nil_code    = cfg_data;
                drp_pkg::CFG_BOOL:   codes_next.bool_code   = cfg_data;
                drp_pkg::CFG_INT:    codes_next.int_code    = cfg_data;
                drp_pkg::CFG_DOUBLE: codes_next.double_code = cfg_data;
                drp_pkg::CFG_STRING: codes_next.string_code = cfg_data;
                default:             codes_next = codes_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            codes_reg.nil_code    <= 8'd0;
            codes_reg.bool_code   <= 8'd1;
            codes_reg.int_code    <= 8'd2;
            codes_reg.double_code <= 8'd3;
            codes_reg.string_code <= 8'd4;
        end
        else
        begin
            codes_reg <= codes_next;
        end
    end

    assign codes = codes_reg;

endmodule

>>> hdl/drp_core.sv
// Parser state and per-byte step logic.
module drp_core
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic [7:0]           data_byte,
    input  logic                 end_of_buffer,
    input  drp_pkg::type_codes_t codes,
    output drp_pkg::token_t      tok
);

    logic [3:0]  phase_reg,      phase_next;
    logic [2:0]  pos_reg,        pos_next;
    logic [63:0] acc_reg,        acc_next;
    logic [31:0] emb_left_reg,   emb_left_next;
    logic [15:0] fields_left_reg, fields_left_next;
    logic [15:0] seg_left_reg,   seg_left_next;
    logic [15:0] cur_field_reg,  cur_field_next;
    logic [1:0]  flags_reg,      flags_next;

    always_comb
    begin
        logic [3:0]  ph;
        logic [3:0]  len;
        logic [63:0] acc_new;
        logic [63:0] val;
        logic        emit;
        logic        do_field_end;
        logic        do_begin;
        logic [15:0] begin_count;

        phase_next       = phase_reg;
        pos_next         = pos_reg;
        acc_next         = acc_reg;
        emb_left_next    = emb_left_reg;
        fields_left_next = fields_left_reg;
        seg_left_next    = seg_left_reg;
        cur_field_next   = cur_field_reg;
        flags_next       = flags_reg;
        tok              = '0;
        ph               = (phase_reg > drp_pkg::PH_STRBYTES) ? drp_pkg::PH_ID : phase_reg;
        len              = drp_pkg::word_len(ph);
        acc_new          = acc_reg | ({56'd0, data_byte} << {pos_reg, 3'b000});
        val              = '0;
        emit             = 1'b0;
        do_field_end     = 1'b0;
        do_begin         = 1'b0;
        begin_count      = fields_left_reg;

        if (step && flags_reg == 2'b00)
        begin
            // byte assembly
            if (len > 4'd1)
            begin
                if (({1'b0, pos_reg} + 4'd1) < len)
                begin
                    pos_next = pos_reg + 3'd1;
                    acc_next = acc_new;
                end
                else
                begin
                    val      = acc_new;
                    acc_next = '0;
                    pos_next = '0;
                    emit     = 1'b1;
                end
            end
            else
            begin
                val  = {56'd0, data_byte};
                emit = 1'b1;
            end

            if (emit)
            begin
                if (ph >= drp_pkg::PH_KEYLEN)
                begin
                    tok.field = cur_field_reg;
                end
                unique case (ph)
                    drp_pkg::PH_ID:
                    begin
                        tok.kind   = drp_pkg::KIND_ID;
                        phase_next = drp_pkg::PH_DIMS;
                    end
                    drp_pkg::PH_DIMS:
                    begin
                        tok.kind      = drp_pkg::KIND_DIMS;
                        emb_left_next = val[31:0];
                        phase_next    = drp_pkg::PH_FCOUNT;
                    end
                    drp_pkg::PH_FCOUNT:
                    begin
                        tok.kind         = drp_pkg::KIND_FCOUNT;
                        fields_left_next = val[15:0];
                        cur_field_next   = '0;
                        if (emb_left_reg != 32'd0)
                        begin
                            phase_next = drp_pkg::PH_EMB;
                        end
                        else
                        begin
                            do_begin    = 1'b1;
                            begin_count = val[15:0];
                        end
                    end
                    drp_pkg::PH_EMB:
                    begin
                        tok.kind      = drp_pkg::KIND_EMB;
                        emb_left_next = emb_left_reg - 32'd1;
                        if (emb_left_reg == 32'd1)
                        begin
                            do_begin = 1'b1;
                        end
                    end
                    drp_pkg::PH_KEYLEN:
                    begin
                        tok.kind      = drp_pkg::KIND_KEYLEN;
                        seg_left_next = val[15:0];
                        phase_next    = (val[15:0] != 16'd0) ? drp_pkg::PH_KEYBYTES
                                                             : drp_pkg::PH_TYPE;
                    end
                    drp_pkg::PH_KEYBYTES:
                    begin
                        tok.kind      = drp_pkg::KIND_KEYBYTE;
                        seg_left_next = seg_left_reg - 16'd1;
                        if (seg_left_reg == 16'd1)
                        begin
                            phase_next = drp_pkg::PH_TYPE;
                        end
                    end
                    drp_pkg::PH_TYPE:
                    begin
                        tok.kind = drp_pkg::KIND_TYPE;
                        // first match wins when codes overlap
                        priority if (data_byte == codes.nil_code)
                            do_field_end = 1'b1;
                        else if (data_byte == codes.bool_code)
                            phase_next = drp_pkg::PH_BOOL;
                        else if (data_byte == codes.int_code)
                            phase_next = drp_pkg::PH_INT;
                        else if (data_byte == codes.double_code)
                            phase_next = drp_pkg::PH_DBL;
                        else if (data_byte == codes.string_code)
                            phase_next = drp_pkg::PH_STRLEN;
                        else
                            flags_next = drp_pkg::FLAG_ERR;
                    end
                    drp_pkg::PH_BOOL:
                    begin
                        tok.kind     = drp_pkg::KIND_BOOL;
                        val          = {63'd0, (data_byte != 8'd0)};
                        do_field_end = 1'b1;
                    end
                    drp_pkg::PH_INT:
                    begin
                        tok.kind     = drp_pkg::KIND_INT;
                        do_field_end = 1'b1;
                    end
                    drp_pkg::PH_DBL:
                    begin
                        tok.kind     = drp_pkg::KIND_DBL;
                        do_field_end = 1'b1;
                    end
                    drp_pkg::PH_STRLEN:
                    begin
                        tok.kind      = drp_pkg::KIND_STRLEN;
                        seg_left_next = val[15:0];
                        if (val[15:0] != 16'd0)
                            phase_next = drp_pkg::PH_STRBYTES;
                        else
                            do_field_end = 1'b1;
                    end
                    default:
                    begin
                        tok.kind      = drp_pkg::KIND_STRBYTE;
                        seg_left_next = seg_left_reg - 16'd1;
                        if (seg_left_reg == 16'd1)
                        begin
                            do_field_end = 1'b1;
                        end
                    end
                endcase

                if (do_field_end)
                begin
                    cur_field_next   = cur_field_reg + 16'd1;
                    fields_left_next = fields_left_reg - 16'd1;
                    begin_count      = fields_left_reg - 16'd1;
                    do_begin         = 1'b1;
                end
                if (do_begin)
                begin
                    if (begin_count == 16'd0)
                        flags_next = drp_pkg::FLAG_DONE;
                    else
                        phase_next = drp_pkg::PH_KEYLEN;
                end
                tok.value = val;
            end

            priority if (flags_next[1])
                tok.status = drp_pkg::ST_BADTYPE;
            else if (flags_next[0])
                tok.status = drp_pkg::ST_DONE;
            else
                tok.status = drp_pkg::ST_BUSY;

            if (end_of_buffer && tok.status == drp_pkg::ST_BUSY)
            begin
                tok.status = drp_pkg::ST_TRUNC;
            end
            tok.emit = emit | end_of_buffer;
        end

        // buffer end always restarts the parse
        if (step && end_of_buffer)
        begin
            phase_next       = drp_pkg::PH_ID;
            pos_next         = '0;
            acc_next         = '0;
            emb_left_next    = '0;
            fields_left_next = '0;
            seg_left_next    = '0;
            cur_field_next   = '0;
            flags_next       = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= drp_pkg::PH_ID;
            pos_reg         <= '0;
            acc_reg         <= '0;
            emb_left_reg    <= '0;
            fields_left_reg <= '0;
            seg_left_reg    <= '0;
            cur_field_reg   <= '0;
            flags_reg       <= '0;
        end
        else
        begin
            phase_reg       <= phase_next;
            pos_reg         <= pos_next;
            acc_reg         <= acc_next;
            emb_left_reg    <= emb_left_next;
            fields_left_reg <= fields_left_next;
            seg_left_reg    <= seg_left_next;
            cur_field_reg   <= cur_field_next;
            flags_reg       <= flags_next;
        end
    end

    a_eob_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (step && end_of_buffer) |=> (phase_reg == drp_pkg::PH_ID && flags_reg == 2'b00
                                     && pos_reg == 3'd0))
        else $error("buffer end did not restart the parser");

    a_busy_has_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (tok.emit && tok.status == drp_pkg::ST_BUSY) |-> (tok.kind != drp_pkg::KIND_NONE))
        else $error("in-progress result without a token");

    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (tok.emit && tok.kind == drp_pkg::KIND_NONE) |-> (tok.value == 64'd0))
        else $error("empty token carries a value");

    a_header_no_field: assert property (@(posedge clk) disable iff (!rst_n)
        (tok.emit && tok.kind != drp_pkg::KIND_NONE && tok.kind < drp_pkg::KIND_KEYLEN)
        |-> (tok.field == 16'd0))
        else $error("header token tagged with a field number");

endmodule
